// ----- rtl/lqm_pkg.sv -----
// ----------------------------------------------------------------------------
// lqm_pkg: shared definitions for the lane queue merge unit
// Request and status codes, register indexes, default sizes and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lqm_pkg;

    // default sizes
    localparam int LANES_DEF      = 4;
    localparam int LANE_DEPTH_DEF = 16;
    localparam int KEY_BITS_DEF   = 24;

    // fixed field widths
    localparam int ID_W       = 16;
    localparam int IN_KEY_W   = 24;
    localparam int REQ_W      = 2;
    localparam int LANE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CAP_W      = 7;
    localparam int S_TDATA_W  = ID_W + 2 * IN_KEY_W;
    localparam int S_TUSER_W  = REQ_W + LANE_W;
    localparam int M_TDATA_W  = ID_W;
    localparam int M_TUSER_W  = 1 + LANE_W + 1 + STATUS_W;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DROP  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_MODE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 4'd1;

    // result select codes
    localparam logic [1:0] RES_ZERO  = 2'd0;
    localparam logic [1:0] RES_DROP  = 2'd1;
    localparam logic [1:0] RES_EMPTY = 2'd2;
    localparam logic [1:0] RES_POP   = 2'd3;

    typedef struct packed {
        logic       load;        // capture an accepted item
        logic       sh_init;     // start a sorted insert at the tail
        logic       rd_shift;    // read the entry below the insert point
        logic       wr_shift;    // move that entry up one place
        logic       wr_new;      // write the new entry
        logic       wr_tail;     // new entry goes at the tail
        logic       pos_dec;
        logic       fill_inc;
        logic       clear_all;
        logic       sc_init;     // start a head scan for a pop
        logic       rd_scan;
        logic       scan_cmp;
        logic       scan_inc;
        logic       pop_commit;
        logic       res_we;
        logic [1:0] res_sel;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             push_drop;
        logic             push_direct;
        logic             shift_gt;
        logic             pos_one;
        logic             scan_empty;
        logic             scan_last;
        logic             top;
        logic             have_best;
        logic             out_free;
    } sts_t;

endpackage

// ----- rtl/lqm_ctrl.sv -----
// ----------------------------------------------------------------------------
// lqm_ctrl: sequencer of the lane queue merge unit
// Steps each item through decode, sorted insert, head scan and result
// hand-off by issuing commands to the datapath.
// ----------------------------------------------------------------------------
module lqm_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  lqm_pkg::sts_t sts_i,
    output lqm_pkg::cmd_t cmd_o
);
    import lqm_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_SH_RD  = 4'd2;
    localparam logic [3:0] ST_SH_CMP = 4'd3;
    localparam logic [3:0] ST_SH_INS = 4'd4;
    localparam logic [3:0] ST_SC_RD  = 4'd5;
    localparam logic [3:0] ST_SC_CMP = 4'd6;
    localparam logic [3:0] ST_SC_END = 4'd7;
    localparam logic [3:0] ST_RESULT = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd_o      = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_o.load = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (sts_i.req)
                    REQ_PUSH: begin
                        if (sts_i.push_drop) begin
                            cmd_o.res_we  = 1'b1;
                            cmd_o.res_sel = RES_DROP;
                            state_next    = ST_RESULT;
                        end else if (sts_i.push_direct) begin
                            cmd_o.wr_new   = 1'b1;
                            cmd_o.wr_tail  = 1'b1;
                            cmd_o.fill_inc = 1'b1;
                            cmd_o.res_we   = 1'b1;
                            cmd_o.res_sel  = RES_ZERO;
                            state_next     = ST_RESULT;
                        end else begin
                            cmd_o.sh_init = 1'b1;
                            state_next    = ST_SH_RD;
                        end
                    end
                    REQ_CLEAR: begin
                        cmd_o.clear_all = 1'b1;
                        cmd_o.res_we    = 1'b1;
                        cmd_o.res_sel   = RES_ZERO;
                        state_next      = ST_RESULT;
                    end
                    REQ_POP: begin
                        cmd_o.sc_init = 1'b1;
                        state_next    = ST_SC_RD;
                    end
                    default: begin
                        cmd_o.res_we  = 1'b1;
                        cmd_o.res_sel = RES_ZERO;
                        state_next    = ST_RESULT;
                    end
                endcase
            end
            ST_SH_RD: begin
                cmd_o.rd_shift = 1'b1;
                state_next     = ST_SH_CMP;
            end
            ST_SH_CMP: begin
                if (sts_i.shift_gt) begin
                    cmd_o.wr_shift = 1'b1;
                    cmd_o.pos_dec  = 1'b1;
                    state_next     = sts_i.pos_one ? ST_SH_INS : ST_SH_RD;
                end else begin
                    cmd_o.wr_new   = 1'b1;
                    cmd_o.fill_inc = 1'b1;
                    cmd_o.res_we   = 1'b1;
                    cmd_o.res_sel  = RES_ZERO;
                    state_next     = ST_RESULT;
                end
            end
            ST_SH_INS: begin
                cmd_o.wr_new   = 1'b1;
                cmd_o.fill_inc = 1'b1;
                cmd_o.res_we   = 1'b1;
                cmd_o.res_sel  = RES_ZERO;
                state_next     = ST_RESULT;
            end
            ST_SC_RD: begin
                if (sts_i.scan_empty) begin
                    if (sts_i.scan_last) begin
                        state_next = ST_SC_END;
                    end else begin
                        cmd_o.scan_inc = 1'b1;
                    end
                end else begin
                    cmd_o.rd_scan = 1'b1;
                    state_next    = ST_SC_CMP;
                end
            end
            ST_SC_CMP: begin
                cmd_o.scan_cmp = 1'b1;
                // in drain mode the first non-empty lane wins
                if (!sts_i.top || sts_i.scan_last) begin
                    state_next = ST_SC_END;
                end else begin
                    cmd_o.scan_inc = 1'b1;
                    state_next     = ST_SC_RD;
                end
            end
            ST_SC_END: begin
                cmd_o.res_we = 1'b1;
                if (sts_i.have_best) begin
                    cmd_o.pop_commit = 1'b1;
                    cmd_o.res_sel    = RES_POP;
                end else begin
                    cmd_o.res_sel = RES_EMPTY;
                end
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (sts_i.out_free) begin
                    cmd_o.out_load = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/lqm_dpath.sv -----
// ----------------------------------------------------------------------------
// lqm_dpath: storage and compare logic of the lane queue merge unit
// Holds the lane memory (circular buffer per lane), fill counts, heads,
// pick counter, configuration, scan compare and the output register.
// ----------------------------------------------------------------------------
module lqm_dpath #(
    parameter int LANES      = lqm_pkg::LANES_DEF,
    parameter int LANE_DEPTH = lqm_pkg::LANE_DEPTH_DEF,
    parameter int KEY_BITS   = lqm_pkg::KEY_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lqm_pkg::cmd_t                  cmd_i,
    output lqm_pkg::sts_t                  sts_o,
    input  logic [lqm_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [lqm_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                           cfg_valid,
    input  logic [lqm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lqm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [lqm_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [lqm_pkg::M_TUSER_W-1:0]  m_tuser
);
    import lqm_pkg::*;

    localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int PW = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;
    localparam int FW = $clog2(LANE_DEPTH + 1);
    localparam int SW = FW + 1;
    localparam int EW = ID_W + 2 * KEY_BITS;

    // logical place in a lane to physical slot of its circular buffer
    function automatic logic [PW-1:0] phys_idx(input logic [PW-1:0] head,
                                               input logic [FW-1:0] lg);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(lg);
        if (sum >= SW'(LANE_DEPTH)) begin
            sum = sum - SW'(LANE_DEPTH);
        end
        return PW'(sum);
    endfunction

    logic [EW-1:0] lane_mem [LANES][LANE_DEPTH];
    logic [EW-1:0] rd_data_reg;

    // control registers
    logic [FW-1:0]    fill_reg  [LANES];
    logic [FW-1:0]    fill_next [LANES];
    logic [PW-1:0]    head_reg  [LANES];
    logic [PW-1:0]    head_next [LANES];
    logic [CAP_W-1:0] picks_reg, picks_next;
    logic             mode_reg, mode_next;
    logic [CAP_W-1:0] cap_reg, cap_next;
    logic             out_valid_reg, out_valid_next;

    // payload registers
    logic [REQ_W-1:0]    req_reg, req_next;
    logic [LANE_W-1:0]   lane_reg, lane_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [KEY_BITS-1:0] dist_reg, dist_next;
    logic [KEY_BITS-1:0] time_reg, time_next;
    logic [FW-1:0]       pos_reg, pos_next;
    logic [LW-1:0]       scan_reg, scan_next;
    logic                have_best_reg, have_best_next;
    logic                top_reg, top_next;
    logic [LW-1:0]       best_lane_reg, best_lane_next;
    logic [KEY_BITS-1:0] best_key_reg, best_key_next;
    logic [ID_W-1:0]     best_id_reg, best_id_next;
    logic                res_vld_reg, res_vld_next;
    logic [ID_W-1:0]     res_id_reg, res_id_next;
    logic [LANE_W-1:0]   res_lane_reg, res_lane_next;
    logic                res_top_reg, res_top_next;
    logic [STATUS_W-1:0] res_st_reg, res_st_next;
    logic                out_vld_reg, out_vld_next;
    logic [ID_W-1:0]     out_id_reg, out_id_next;
    logic [LANE_W-1:0]   out_lane_reg, out_lane_next;
    logic                out_top_reg, out_top_next;
    logic [STATUS_W-1:0] out_st_reg, out_st_next;

    logic [LW-1:0]       lane_idx;
    logic                lane_ok;
    logic [ID_W-1:0]     rd_id;
    logic [KEY_BITS-1:0] rd_dist;
    logic [KEY_BITS-1:0] rd_time;
    logic [KEY_BITS-1:0] rd_key;
    logic                take;
    logic                rd_en;
    logic [LW-1:0]       rd_lane;
    logic [PW-1:0]       rd_pos;
    logic                mem_we;
    logic [PW-1:0]       wr_pos;
    logic [EW-1:0]       wr_data;

    assign lane_idx = LW'(lane_reg);
    assign lane_ok  = 32'(lane_reg) < LANES;

    assign rd_id   = rd_data_reg[ID_W-1:0];
    assign rd_dist = rd_data_reg[ID_W+KEY_BITS-1:ID_W];
    assign rd_time = rd_data_reg[EW-1:ID_W+KEY_BITS];
    assign rd_key  = mode_reg ? rd_time : rd_dist;
    assign take    = !have_best_reg || (top_reg && (rd_key < best_key_reg));

    // memory port control
    assign rd_en   = cmd_i.rd_shift || cmd_i.rd_scan;
    assign rd_lane = cmd_i.rd_scan ? scan_reg : lane_idx;
    assign rd_pos  = cmd_i.rd_scan ? head_reg[scan_reg]
                                   : phys_idx(head_reg[lane_idx], pos_reg - FW'(1));
    assign mem_we  = cmd_i.wr_shift || cmd_i.wr_new;
    assign wr_pos  = phys_idx(head_reg[lane_idx],
                              cmd_i.wr_tail ? fill_reg[lane_idx] : pos_reg);
    assign wr_data = cmd_i.wr_shift ? rd_data_reg : {time_reg, dist_reg, id_reg};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            lane_mem[lane_idx][wr_pos] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= lane_mem[rd_lane][rd_pos];
        end
    end

    // status to the controller
    always_comb begin
        sts_o             = '0;
        sts_o.req         = req_reg;
        sts_o.push_drop   = !lane_ok || (fill_reg[lane_idx] >= FW'(LANE_DEPTH));
        sts_o.push_direct = (lane_idx == LW'(LANES - 1)) || (fill_reg[lane_idx] == '0);
        sts_o.shift_gt    = rd_dist > dist_reg;
        sts_o.pos_one     = pos_reg == FW'(1);
        sts_o.scan_empty  = fill_reg[scan_reg] == '0;
        sts_o.scan_last   = scan_reg == LW'(LANES - 1);
        sts_o.top         = top_reg;
        sts_o.have_best   = have_best_reg;
        sts_o.out_free    = !out_valid_reg || m_tready;
    end

    always_comb begin
        fill_next      = fill_reg;
        head_next      = head_reg;
        picks_next     = picks_reg;
        mode_next      = mode_reg;
        cap_next       = cap_reg;
        out_valid_next = out_valid_reg;
        req_next       = req_reg;
        lane_next      = lane_reg;
        id_next        = id_reg;
        dist_next      = dist_reg;
        time_next      = time_reg;
        pos_next       = pos_reg;
        scan_next      = scan_reg;
        have_best_next = have_best_reg;
        top_next       = top_reg;
        best_lane_next = best_lane_reg;
        best_key_next  = best_key_reg;
        best_id_next   = best_id_reg;
        res_vld_next   = res_vld_reg;
        res_id_next    = res_id_reg;
        res_lane_next  = res_lane_reg;
        res_top_next   = res_top_reg;
        res_st_next    = res_st_reg;
        out_vld_next   = out_vld_reg;
        out_id_next    = out_id_reg;
        out_lane_next  = out_lane_reg;
        out_top_next   = out_top_reg;
        out_st_next    = out_st_reg;

        if (cmd_i.load) begin
            req_next  = s_tuser[REQ_W-1:0];
            lane_next = s_tuser[REQ_W+LANE_W-1:REQ_W];
            id_next   = s_tdata[ID_W-1:0];
            dist_next = KEY_BITS'(s_tdata[ID_W+IN_KEY_W-1:ID_W]);
            time_next = KEY_BITS'(s_tdata[ID_W+2*IN_KEY_W-1:ID_W+IN_KEY_W]);
        end

        if (cmd_i.sh_init) begin
            pos_next = fill_reg[lane_idx];
        end
        if (cmd_i.pos_dec) begin
            pos_next = pos_reg - FW'(1);
        end
        if (cmd_i.fill_inc) begin
            fill_next[lane_idx] = fill_reg[lane_idx] + FW'(1);
        end

        if (cmd_i.sc_init) begin
            scan_next      = '0;
            have_best_next = 1'b0;
            top_next       = picks_reg < cap_reg;
        end
        if (cmd_i.scan_inc) begin
            scan_next = scan_reg + LW'(1);
        end
        if (cmd_i.scan_cmp && take) begin
            have_best_next = 1'b1;
            best_lane_next = scan_reg;
            best_key_next  = rd_key;
            best_id_next   = rd_id;
        end
        if (cmd_i.pop_commit) begin
            fill_next[best_lane_reg] = fill_reg[best_lane_reg] - FW'(1);
            head_next[best_lane_reg] = phys_idx(head_reg[best_lane_reg], FW'(1));
            if (top_reg) begin
                picks_next = picks_reg + CAP_W'(1);
            end
        end

        if (cmd_i.clear_all) begin
            for (int i = 0; i < LANES; i++) begin
                fill_next[i] = '0;
            end
            picks_next = '0;
        end

        if (cmd_i.res_we) begin
            res_vld_next  = 1'b0;
            res_id_next   = '0;
            res_lane_next = '0;
            res_top_next  = 1'b0;
            res_st_next   = ST_OK;
            case (cmd_i.res_sel)
                RES_DROP:  res_st_next = ST_DROP;
                RES_EMPTY: res_st_next = ST_EMPTY;
                RES_POP: begin
                    res_vld_next  = 1'b1;
                    res_id_next   = best_id_reg;
                    res_lane_next = LANE_W'(best_lane_reg);
                    res_top_next  = top_reg;
                end
                default: res_st_next = ST_OK;
            endcase
        end

        if (cmd_i.out_load) begin
            out_valid_next = 1'b1;
            out_vld_next   = res_vld_reg;
            out_id_next    = res_id_reg;
            out_lane_next  = res_lane_reg;
            out_top_next   = res_top_reg;
            out_st_next    = res_st_reg;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            case (cfg_index)
                REG_ORDER_MODE: mode_next = cfg_data[0];
                REG_CAPACITY:   cap_next  = cfg_data[CAP_W-1:0];
                default:        mode_next = mode_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LANES; i++) begin
                fill_reg[i] <= '0;
                head_reg[i] <= '0;
            end
            picks_reg     <= '0;
            mode_reg      <= 1'b0;
            cap_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            fill_reg      <= fill_next;
            head_reg      <= head_next;
            picks_reg     <= picks_next;
            mode_reg      <= mode_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        lane_reg      <= lane_next;
        id_reg        <= id_next;
        dist_reg      <= dist_next;
        time_reg      <= time_next;
        pos_reg       <= pos_next;
        scan_reg      <= scan_next;
        have_best_reg <= have_best_next;
        top_reg       <= top_next;
        best_lane_reg <= best_lane_next;
        best_key_reg  <= best_key_next;
        best_id_reg   <= best_id_next;
        res_vld_reg   <= res_vld_next;
        res_id_reg    <= res_id_next;
        res_lane_reg  <= res_lane_next;
        res_top_reg   <= res_top_next;
        res_st_reg    <= res_st_next;
        out_vld_reg   <= out_vld_next;
        out_id_reg    <= out_id_next;
        out_lane_reg  <= out_lane_next;
        out_top_reg   <= out_top_next;
        out_st_reg    <= out_st_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_id_reg;
    assign m_tuser  = {out_st_reg, out_top_reg, out_lane_reg, out_vld_reg};

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg[0] <= FW'(LANE_DEPTH))
        else $error("lane fill count beyond depth");

    a_picks_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (picks_reg > $past(picks_reg))
        |-> $past(cmd_i.pop_commit && top_reg))
        else $error("pick count moved without a minimum-key pop");

    a_shift_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.wr_shift |-> (pos_reg != '0))
        else $error("shift below the lane head");

    a_pop_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_vld_reg |-> (out_st_reg == ST_OK) && (32'(out_lane_reg) < LANES))
        else $error("returned entry with bad status or lane");

endmodule

// ----- rtl/lane_queue_top_c_merge_unit.sv -----
// ----------------------------------------------------------------------------
// lane_queue_top_c_merge_unit: per-lane sorted queues with a top-C merge
// Usage notes:
// Requests enter on the s_axis channel (push, pop or clear); every item
// yields exactly one result item on the m_axis channel. Registers are
// written through the cfg channel, which is always ready and should only
// be used while no request is in flight.
// The work per item, from acceptance to the result landing in the output
// register, is set by the single-port lane memory and the head scan:
//   push to the unsorted lane, to an empty lane, clear, drop: decode only
//   sorted push: a read and a compare per entry looked at, larger ones moved up
//   pop: a read and a compare per non-empty lane, a skip per empty lane; drain
//        mode stops at the first non-empty lane
// One item is worked on at a time; s_axis_tready is high while idle.
// The result waits in an output register, so a stalled m_axis side does
// not block the next request until that one has its own result ready.
// Reset (aresetn low, synchronous) empties all lanes, zeroes the pick
// count and both registers, and drops any pending result. Lane contents
// need no clearing pass.
// ----------------------------------------------------------------------------
module lane_queue_top_c_merge_unit #(
    parameter int LANES      = lqm_pkg::LANES_DEF,
    parameter int LANE_DEPTH = lqm_pkg::LANE_DEPTH_DEF,
    parameter int KEY_BITS   = lqm_pkg::KEY_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [lqm_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // entry_id, distance_key, time_key
    input  logic [lqm_pkg::S_TUSER_W-1:0]  s_axis_tuser,  // req_type, lane
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [lqm_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // out_id
    output logic [lqm_pkg::M_TUSER_W-1:0]  m_axis_tuser,  // valid_res, out_lane,
                                                          // from_top_phase, status
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lqm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lqm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lqm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    lqm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .sts_i   (sts),
        .cmd_o   (cmd)
    );

    lqm_dpath #(
        .LANES      (LANES),
        .LANE_DEPTH (LANE_DEPTH),
        .KEY_BITS   (KEY_BITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_i     (cmd),
        .sts_o     (sts),
        .s_tdata   (s_axis_tdata),
        .s_tuser   (s_axis_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_axis_tready),
        .m_tvalid  (m_axis_tvalid),
        .m_tdata   (m_axis_tdata),
        .m_tuser   (m_axis_tuser)
    );

endmodule
